[rtl/core/alfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alfe_pkg
// Shared types, codes and defaults for the addressable LED frame encoder.
// ----------------------------------------------------------------------------
package alfe_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned LedCountDef   = 16;
  localparam int unsigned ResetSlotsDef = 64;
  localparam int unsigned FrameBytesDef = 512;

  localparam int unsigned PosW       = 12;  // frame byte counter
  localparam int unsigned BitsPerLed = 24;
  localparam int unsigned PixelW     = 24;  // {red, green, blue}
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;

  typedef enum logic [2:0] {
    ACT_SET_PIXEL = 3'd0,
    ACT_SET_CODE  = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_START     = 3'd3,
    ACT_TICK      = 3'd4
  } action_e;

  // Register index, taken from paddr[2]
  localparam logic REG_ONE_PATTERN  = 1'b0;
  localparam logic REG_ZERO_PATTERN = 1'b1;

  localparam logic [7:0] ONE_PATTERN_RST  = 8'd248;
  localparam logic [7:0] ZERO_PATTERN_RST = 8'd192;

  // Colour codes for set by code
  localparam logic [7:0] COLOR_RED   = 8'd1;
  localparam logic [7:0] COLOR_BLUE  = 8'd2;
  localparam logic [7:0] COLOR_GREEN = 8'd3;
  localparam logic [7:0] COLOR_WHITE = 8'd4;

  // Channel order on the wire: green, red, blue
  localparam logic [1:0] CH_GREEN = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [2:0] BIT_LAST = 3'd7;

  typedef logic [PixelW-1:0] pixel_t;

  // Map a colour code and a level to a packed {red, green, blue} pixel
  function automatic pixel_t code_to_pixel(logic [7:0] code, logic [7:0] level);
    pixel_t pix;
    pix = '0;
    unique case (code)
      COLOR_RED:   pix = {level, 8'h00, 8'h00};
      COLOR_BLUE:  pix = {8'h00, 8'h00, level};
      COLOR_GREEN: pix = {8'h00, level, 8'h00};
      COLOR_WHITE: pix = {level, level, level};
      default:     pix = '0;
    endcase
    return pix;
  endfunction

endpackage

[rtl/core/alfe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alfe_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module alfe_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/addressable_led_frame_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_frame_encoder
// Pixel store and SPI bit-pattern frame generator for addressable LED strips.
// ----------------------------------------------------------------------------
// A tick's byte passes the input register, stage 2 and the output register.
// Throughput: one item per cycle unless stalled; one RAM read per active tick.
// Reset: frame idle, patterns at 248 / 192, every pixel reads as black (per-LED
// valid flags clear at once, no clearing pass).
// ----------------------------------------------------------------------------
module addressable_led_frame_encoder #(
  parameter int unsigned LED_COUNT   = alfe_pkg::LedCountDef,
  parameter int unsigned RESET_SLOTS = alfe_pkg::ResetSlotsDef,
  parameter int unsigned FRAME_BYTES = alfe_pkg::FrameBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  // Command / tick channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  action_i,
  input  logic [7:0]                  pixel_index_i,
  input  logic [7:0]                  red_level_i,
  input  logic [7:0]                  green_level_i,
  input  logic [7:0]                  blue_level_i,
  input  logic [7:0]                  color_code_i,
  input  logic [7:0]                  brightness_i,

  // SPI byte channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  spi_byte_o,
  output logic                        frame_last_o,

  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [alfe_pkg::PaddrW-1:0] paddr,
  input  logic [alfe_pkg::PdataW-1:0] pwdata,
  output logic [alfe_pkg::PdataW-1:0] prdata,
  output logic                        pready
);

  import alfe_pkg::*;

  localparam int unsigned LedW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // Frame layout bounds, one bit wider than the position counter
  localparam logic [PosW:0] PixStart = (PosW + 1)'(RESET_SLOTS);
  localparam logic [PosW:0] PixEnd   = (PosW + 1)'(RESET_SLOTS + BitsPerLed * LED_COUNT);
  localparam logic [PosW:0] LastPos  = (PosW + 1)'(FRAME_BYTES - 1);
  localparam logic [8:0]    LedLimit = 9'(LED_COUNT);
  localparam logic [LedW-1:0] LedMax = LedW'(LED_COUNT - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] one_pat_q, zero_pat_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_pat_q  <= ONE_PATTERN_RST;
      zero_pat_q <= ZERO_PATTERN_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ONE_PATTERN:  one_pat_q  <= pwdata[7:0];
        REG_ZERO_PATTERN: zero_pat_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ONE_PATTERN:  prdata = {{(PdataW - 8){1'b0}}, one_pat_q};
      REG_ZERO_PATTERN: prdata = {{(PdataW - 8){1'b0}}, zero_pat_q};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: each stage advances when the one after it is empty or leaving
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_adv, s2_free, s1_adv;

  assign out_free   = ~out_valid_q | out_ready_i;
  assign s2_adv     = s2_valid_q & out_free;
  assign s2_free    = ~s2_valid_q | out_free;
  assign s1_adv     = s1_valid_q & s2_free;
  assign in_ready_o = ~s1_valid_q | s2_free;

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic [2:0] s1_action_q;
  logic [7:0] s1_index_q, s1_red_q, s1_green_q, s1_blue_q, s1_code_q, s1_level_q;
  logic       in_xfer;

  assign in_xfer = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_action_q <= action_i;
      s1_index_q  <= pixel_index_i;
      s1_red_q    <= red_level_i;
      s1_green_q  <= green_level_i;
      s1_blue_q   <= blue_level_i;
      s1_code_q   <= color_code_i;
      s1_level_q  <= brightness_i;
    end
  end

  // --------------------------------------------------------------------------
  // Frame sequencer and pixel store control (acts as the item leaves stage 1)
  // --------------------------------------------------------------------------
  logic                 active_q, active_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [LedW-1:0]      led_q, led_d;
  logic [1:0]           chan_q, chan_d;
  logic [2:0]           bit_q, bit_d;
  logic [LED_COUNT-1:0] pix_vld_q, pix_vld_d;

  logic            idx_ok, in_pix, is_last, emit;
  logic            ram_we;
  pixel_t          ram_wdata;
  logic [LedW-1:0] ram_waddr;
  pixel_t          ram_rdata;

  assign idx_ok  = {1'b0, s1_index_q} < LedLimit;
  assign in_pix  = ({1'b0, pos_q} >= PixStart) && ({1'b0, pos_q} < PixEnd);
  assign is_last = {1'b0, pos_q} >= LastPos;
  assign ram_waddr = s1_index_q[LedW-1:0];

  always_comb begin
    active_d  = active_q;
    pos_d     = pos_q;
    led_d     = led_q;
    chan_d    = chan_q;
    bit_d     = bit_q;
    pix_vld_d = pix_vld_q;
    emit      = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = {s1_red_q, s1_green_q, s1_blue_q};

    if (s1_adv) begin
      unique case (action_e'(s1_action_q))
        ACT_TICK: begin
          if (active_q) begin
            emit = 1'b1;
            if (is_last) begin
              // End of frame: drop back to idle and rewind
              active_d = 1'b0;
              pos_d    = '0;
              led_d    = '0;
              chan_d   = CH_GREEN;
              bit_d    = '0;
            end else begin
              pos_d = pos_q + PosW'(1);
              if (in_pix) begin
                bit_d = bit_q + 3'd1;
                if (bit_q == BIT_LAST) begin
                  if (chan_q == CH_BLUE) begin
                    chan_d = CH_GREEN;
                    led_d  = (led_q == LedMax) ? '0 : led_q + LedW'(1);
                  end else begin
                    chan_d = chan_q + 2'd1;
                  end
                end
              end
            end
          end
        end
        ACT_SET_PIXEL: begin
          if (!active_q && idx_ok) begin
            ram_we                 = 1'b1;
            pix_vld_d[ram_waddr]   = 1'b1;
          end
        end
        ACT_SET_CODE: begin
          if (!active_q && idx_ok) begin
            ram_we                 = 1'b1;
            ram_wdata              = code_to_pixel(s1_code_q, s1_level_q);
            pix_vld_d[ram_waddr]   = 1'b1;
          end
        end
        ACT_CLEAR: begin
          if (!active_q) begin
            pix_vld_d = '0;
          end
        end
        ACT_START: begin
          if (!active_q) begin
            active_d = 1'b1;
            pos_d    = '0;
            led_d    = '0;
            chan_d   = CH_GREEN;
            bit_d    = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      pos_q     <= '0;
      led_q     <= '0;
      chan_q    <= CH_GREEN;
      bit_q     <= '0;
      pix_vld_q <= '0;
    end else begin
      active_q  <= active_d;
      pos_q     <= pos_d;
      led_q     <= led_d;
      chan_q    <= chan_d;
      bit_q     <= bit_d;
      pix_vld_q <= pix_vld_d;
    end
  end

  // Pixel store; read data lines up with stage 2
  alfe_ram #(
    .Width (PixelW),
    .Depth (LED_COUNT),
    .AddrW (LedW)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (emit),
    .raddr_i (led_q),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 2: byte slot descriptor, alongside the RAM read
  // --------------------------------------------------------------------------
  logic       s2_in_pix_q, s2_vld_q, s2_last_q;
  logic [1:0] s2_chan_q;
  logic [2:0] s2_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= emit;
    end else if (s2_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s2_in_pix_q <= in_pix;
      s2_vld_q    <= pix_vld_q[led_q];
      s2_last_q   <= is_last;
      s2_chan_q   <= chan_q;
      s2_bit_q    <= bit_q;
    end
  end

  // Pick the colour byte, then the bit, MSB first; unwritten pixels read black
  logic [7:0] level;
  logic [7:0] byte_d;

  always_comb begin
    level = 8'h00;
    if (s2_vld_q) begin
      unique case (s2_chan_q)
        CH_GREEN: level = ram_rdata[15:8];
        CH_RED:   level = ram_rdata[23:16];
        CH_BLUE:  level = ram_rdata[7:0];
        default:  level = 8'h00;
      endcase
    end
    if (!s2_in_pix_q) begin
      byte_d = 8'h00;
    end else if (level[BIT_LAST - s2_bit_q]) begin
      byte_d = one_pat_q;
    end else begin
      byte_d = zero_pat_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [7:0] spi_byte_q;
  logic       frame_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      spi_byte_q   <= byte_d;
      frame_last_q <= s2_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign spi_byte_o   = spi_byte_q;
  assign frame_last_o = frame_last_q;

endmodule
